### rtl/arol_pkg.sv
// Package with the payload types, link types and constants of the address range owner lookup.
package arol_pkg;

   localparam int unsigned ADDR_WIDTH = 64;
   localparam int unsigned TAG_WIDTH  = 32;
   localparam int unsigned DIST_WIDTH = 32;

   // Request command codes.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Reset value of the distance limit register.
   localparam logic [DIST_WIDTH-1:0] MAX_DISTANCE_RESET = DIST_WIDTH'(32'h0010_0000);

   typedef struct packed {
      logic                  command;
      logic [ADDR_WIDTH-1:0] host_address;
      logic [TAG_WIDTH-1:0]  guest_address;
   } req_type;

   typedef struct packed {
      logic [TAG_WIDTH-1:0] owner_tag;
      logic                 hit;
      logic                 insert_refused;
   } rsp_type;

   // What a cell shows its right neighbor for an insert.
   typedef struct packed {
      logic                  valid;
      logic                  gt;
      logic [ADDR_WIDTH-1:0] start;
      logic [TAG_WIDTH-1:0]  tag;
   } link_type;

   // A lookup probe walking down the chain, carrying the best floor entry so far.
   typedef struct packed {
      logic                  valid;
      logic [ADDR_WIDTH-1:0] addr;
      logic                  found;
      logic [ADDR_WIDTH-1:0] start;
      logic [TAG_WIDTH-1:0]  tag;
   } probe_type;

endpackage

### rtl/arol_cell.sv
// One cell of the sorted table: holds an entry and one stage of the lookup probe path.
module arol_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           ins_en,
   input  logic [arol_pkg::ADDR_WIDTH-1:0] ins_start,
   input  logic [arol_pkg::TAG_WIDTH-1:0]  ins_tag,
   input  arol_pkg::link_type             link_prev,
   output arol_pkg::link_type             link_next,
   input  arol_pkg::probe_type            probe_prev,
   output arol_pkg::probe_type            probe_next
);

   logic                           valid_ff, valid_in;
   logic [arol_pkg::ADDR_WIDTH-1:0] start_ff, start_in;
   logic [arol_pkg::TAG_WIDTH-1:0]  tag_ff, tag_in;
   arol_pkg::probe_type            probe_ff, probe_in;
   logic                           gt_self;
   logic                           shift_from_left;
   logic                           place_here;
   logic                           covers;

   always_comb begin
      gt_self    = valid_ff && (start_ff > ins_start);
      // Entries to the left that start above the new one move right by one cell.
      shift_from_left = link_prev.valid && link_prev.gt;
      // The new entry lands in the first cell that is empty or starts above it.
      place_here = link_prev.valid && !link_prev.gt && !(valid_ff && !gt_self);

      valid_in = valid_ff;
      start_in = start_ff;
      tag_in   = tag_ff;
      if (ins_en) begin
         if (shift_from_left) begin
            valid_in = 1'b1;
            start_in = link_prev.start;
            tag_in   = link_prev.tag;
         end else if (place_here) begin
            valid_in = 1'b1;
            start_in = ins_start;
            tag_in   = ins_tag;
         end
      end

      link_next.valid = valid_ff;
      link_next.gt    = gt_self;
      link_next.start = start_ff;
      link_next.tag   = tag_ff;

      // The table is sorted, so the last covering entry seen is the floor entry.
      covers   = valid_ff && (start_ff <= probe_prev.addr);
      probe_in = probe_prev;
      if (covers) begin
         probe_in.found = 1'b1;
         probe_in.start = start_ff;
         probe_in.tag   = tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         probe_ff.valid <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         probe_ff.valid <= probe_in.valid;
      end
      start_ff       <= start_in;
      tag_ff         <= tag_in;
      probe_ff.addr  <= probe_in.addr;
      probe_ff.found <= probe_in.found;
      probe_ff.start <= probe_in.start;
      probe_ff.tag   <= probe_in.tag;
   end

   assign probe_next = probe_ff;

endmodule

### rtl/address_range_owner_lookup_unit.sv
// Top level of the address range owner lookup: a sorted chain of table cells with control.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_ready  req_data  (arol_pkg::req_type)
//   rsp_      out         rsp_valid / rsp_ready  rsp_data  (arol_pkg::rsp_type)
//   csr_      in          csr_we, no wait        csr_wdata (max_distance)
//
// One request is in work at a time. An insert updates every cell in parallel at the
// accepting edge. A lookup probe walks the chain one cell per cycle and gets its distance
// check at the chain end. A finished response waits for a free output register, and that
// register holds it until rsp_ready. The next request is taken in the same cycle as the
// response shows.
// Synchronous reset clears every cell's valid bit and sets max_distance to 1 << 20.
module address_range_owner_lookup_unit #(
   parameter int unsigned TABLE_ENTRIES = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  arol_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output arol_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [arol_pkg::DIST_WIDTH-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_HOLD
   } state_type;

   state_type                        state_ff, state_in;
   logic [arol_pkg::DIST_WIDTH-1:0]  max_dist_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   arol_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   arol_pkg::rsp_type                pend_ff, pend_in;

   arol_pkg::link_type               link [0:TABLE_ENTRIES];
   arol_pkg::probe_type              probe [0:TABLE_ENTRIES];

   logic                             accept;
   logic                             is_insert;
   logic                             table_full;
   logic                             ins_en;
   logic                             rsp_free;
   logic [arol_pkg::ADDR_WIDTH-1:0]  offset;
   logic                             in_range;
   arol_pkg::probe_type              probe_exit;

   // The left end of the chain looks like a valid entry that never starts above anything.
   assign link[0] = '{valid: 1'b1, gt: 1'b0, start: '0, tag: '0};

   // A new lookup probe enters the first cell when a lookup request is accepted.
   assign probe[0] = '{valid: accept && (req_data.command == arol_pkg::CMD_LOOKUP),
                       addr:  req_data.host_address,
                       found: 1'b0,
                       start: '0,
                       tag:   '0};

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      arol_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ins_en     (ins_en),
         .ins_start  (req_data.host_address),
         .ins_tag    (req_data.guest_address),
         .link_prev  (link[i]),
         .link_next  (link[i+1]),
         .probe_prev (probe[i]),
         .probe_next (probe[i+1])
      );
   end

   // The last cell holds an entry only when the table is full.
   assign table_full = link[TABLE_ENTRIES].valid;
   assign probe_exit = probe[TABLE_ENTRIES];

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_insert = (req_data.command == arol_pkg::CMD_INSERT);
   // Zero tags are dropped silently; a full table refuses the insert.
   assign ins_en    = accept && is_insert && (req_data.guest_address != '0) && !table_full;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign offset    = probe_exit.addr - probe_exit.start;
   assign in_range  = probe_exit.found &&
                      (offset <= {{(arol_pkg::ADDR_WIDTH-arol_pkg::DIST_WIDTH){1'b0}},
                                  max_dist_ff});

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (is_insert) begin
                  pend_in.owner_tag      = '0;
                  pend_in.hit            = 1'b0;
                  pend_in.insert_refused = (req_data.guest_address != '0) && table_full;
                  state_in               = S_HOLD;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (probe_exit.valid) begin
               pend_in.owner_tag      = in_range ? probe_exit.tag : '0;
               pend_in.hit            = in_range;
               pend_in.insert_refused = 1'b0;
               state_in               = S_HOLD;
            end
         end
         S_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         max_dist_ff  <= arol_pkg::MAX_DISTANCE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            max_dist_ff <= csr_wdata;
         end
      end
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/arol_checker.sv
// Port-level checker for the address range owner lookup, with its bind statement.
module arol_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input arol_pkg::rsp_type rsp_data
);

   // A response that is not taken stays, unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed or dropped while stalled");

   // Zero tags never enter the table, so a hit always names a nonzero owner.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> (rsp_data.owner_tag != '0) && !rsp_data.insert_refused)
      else $error("hit with zero tag or refusal flag");

   // A miss carries no tag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.owner_tag == '0)
      else $error("nonzero tag on a miss");

   // Only one request is in work: the cycle after an acceptance takes no other.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

endmodule

bind address_range_owner_lookup_unit arol_checker u_arol_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
